### sv/mavlink_frame_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef MAVLINK_FRAME_DEFRAMER_MACROS_SVH
`define MAVLINK_FRAME_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define MFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deframer check failed");
// Next-cycle implication.
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deframer check failed");
`else
`define MFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/mfd_pkg.sv
// Types and constants of the MAVLink frame deframer.
package mfd_pkg;

	localparam logic [7:0] STX_V1          = 8'hFE;
	localparam logic [7:0] STX_V2          = 8'hFD;
	localparam int unsigned INCOMPAT_SIGNED_BIT = 0;
	localparam logic [3:0] HDR_V1          = 4'd6;
	localparam logic [3:0] HDR_V2          = 4'd10;
	localparam logic [8:0] CRC_BYTES       = 9'd2;
	localparam logic [8:0] SIG_BYTES       = 9'd13;
	localparam logic [8:0] MAX_REMAIN      = 9'd270;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_LEN    = 4'b0010,
		PH_HEADER = 4'b0100,
		PH_REST   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		logic        in_frame;
		logic [8:0]  byte_pos;
		logic        frame_done;
		logic [8:0]  frame_bytes;
		logic        is_v2;
		logic [7:0]  payload_bytes;
		logic [3:0]  payload_start;
		logic [7:0]  system_id;
		logic [7:0]  component_id;
		logic [23:0] message_id;
		logic        overflow_drop;
	} result_t;

endpackage

### sv/mfd_in_if.sv
// Byte input channel of the deframer.
interface mfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

### sv/mfd_out_if.sv
// Result channel of the deframer.
interface mfd_out_if;
	logic            valid;
	logic            ready;
	mfd_pkg::result_t res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

### sv/mavlink_frame_deframer.sv
// MAVLink v1/v2 frame deframer: byte echo with frame position and frame summary.
//
//   channel  dir  payload                                  transfer when
//   in       in   data_byte                                in.valid & in.ready
//   out      out  res (echo, position, summary, drop flag) out.valid & out.ready
//
// One byte per cycle sustained while out accepts results; a byte's result passes through
// the input register, then the result register, before it is shown on out.
// The frame state is updated in the same cycle a byte moves from the input
// register to the result register, so consecutive bytes never wait on each other.
// A stall on out holds the result register; the input register still takes one
// more byte, after which in.ready drops until the result moves on.
// Reset (arst_n low) empties both registers and returns the parser to hunting.
`include "mavlink_frame_deframer_macros.svh"

module mavlink_frame_deframer #(
	parameter int MAX_FRAME = 280
) (
	input  logic clk,
	input  logic arst_n,
	mfd_in_if.sink    in,
	mfd_out_if.source out
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register
	logic             out_valid_q;
	mfd_pkg::result_t res_q;

	// Frame state
	mfd_pkg::phase_t phase_q, phase_d;
	logic        v2_q, v2_d;
	logic [3:0]  hdr_q, hdr_d;
	logic [8:0]  fill_q, fill_d;
	logic [7:0]  plen_q, plen_d;
	logic        signed_q, signed_d;
	logic [8:0]  left_q, left_d;
	logic [7:0]  sys_q, sys_d;
	logic [7:0]  comp_q, comp_d;
	logic [23:0] msg_q, msg_d;

	logic             adv;
	logic             load;
	logic [8:0]       fill_inc;
	logic [8:0]       left_dec;
	mfd_pkg::result_t res_d;

	// The result register frees up when empty or when its contents transfer.
	assign adv      = !out_valid_q || out.ready;
	assign load     = valid_s1 && adv;
	assign in.ready = !valid_s1 || adv;

	assign out.valid = out_valid_q;
	assign out.res   = res_q;

	assign fill_inc = fill_q + 9'd1;
	assign left_dec = left_q - 9'd1;

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_d  = phase_q;
		v2_d     = v2_q;
		hdr_d    = hdr_q;
		fill_d   = fill_q;
		plen_d   = plen_q;
		signed_d = signed_q;
		left_d   = left_q;
		sys_d    = sys_q;
		comp_d   = comp_q;
		msg_d    = msg_q;

		res_d           = '0;
		res_d.echo_byte = byte_s1;

		unique case (phase_q)
			mfd_pkg::PH_HUNT: begin
				// Open a frame on either start byte; everything else passes as idle.
				if (byte_s1 == mfd_pkg::STX_V1 || byte_s1 == mfd_pkg::STX_V2) begin
					v2_d     = (byte_s1 == mfd_pkg::STX_V2);
					hdr_d    = (byte_s1 == mfd_pkg::STX_V2) ? mfd_pkg::HDR_V2
					                                         : mfd_pkg::HDR_V1;
					signed_d = 1'b0;
					sys_d    = '0;
					comp_d   = '0;
					msg_d    = '0;
					fill_d   = 9'd1;
					phase_d  = mfd_pkg::PH_LEN;
					res_d.in_frame = 1'b1;
				end
			end
			mfd_pkg::PH_LEN: begin
				res_d.in_frame = 1'b1;
				res_d.byte_pos = fill_q;
				fill_d  = fill_inc;
				plen_d  = byte_s1;
				phase_d = mfd_pkg::PH_HEADER;
			end
			mfd_pkg::PH_HEADER: begin
				res_d.in_frame = 1'b1;
				res_d.byte_pos = fill_q;
				fill_d = fill_inc;
				// Capture the header fields at their version-specific offsets.
				if (v2_q) begin
					case (fill_q)
						9'd2: signed_d = byte_s1[mfd_pkg::INCOMPAT_SIGNED_BIT];
						9'd5: sys_d = byte_s1;
						9'd6: comp_d = byte_s1;
						9'd7: msg_d[7:0] = byte_s1;
						9'd8: msg_d[15:8] = byte_s1;
						9'd9: msg_d[23:16] = byte_s1;
						default: ;
					endcase
				end else begin
					case (fill_q)
						9'd3: sys_d = byte_s1;
						9'd4: comp_d = byte_s1;
						9'd5: msg_d = {16'd0, byte_s1};
						default: ;
					endcase
				end
				// Header complete: load the count of payload, CRC and signature.
				if (fill_inc == {5'd0, hdr_q}) begin
					left_d  = {1'b0, plen_q} + mfd_pkg::CRC_BYTES
					        + ((v2_q && signed_q) ? mfd_pkg::SIG_BYTES : 9'd0);
					phase_d = mfd_pkg::PH_REST;
				end
			end
			mfd_pkg::PH_REST: begin
				res_d.in_frame = 1'b1;
				res_d.byte_pos = fill_q;
				fill_d = fill_inc;
				left_d = left_dec;
				if (left_dec == 9'd0) begin
					res_d.frame_done    = 1'b1;
					res_d.frame_bytes   = fill_inc;
					res_d.is_v2         = v2_q;
					res_d.payload_bytes = plen_q;
					res_d.payload_start = hdr_q;
					res_d.system_id     = sys_q;
					res_d.component_id  = comp_q;
					res_d.message_id    = msg_q;
					phase_d = mfd_pkg::PH_HUNT;
					fill_d  = '0;
				end
			end
			default: ;
		endcase

		// Size guard: drop a frame that reaches the limit without completing.
		if (phase_q != mfd_pkg::PH_HUNT && !res_d.frame_done
		    && fill_inc >= 9'(MAX_FRAME)) begin
			res_d.overflow_drop = 1'b1;
			phase_d = mfd_pkg::PH_HUNT;
			fill_d  = '0;
		end
	end

	// Control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= mfd_pkg::PH_HUNT;
			v2_q        <= 1'b0;
			hdr_q       <= '0;
			fill_q      <= '0;
			plen_q      <= '0;
			signed_q    <= 1'b0;
			left_q      <= '0;
			sys_q       <= '0;
			comp_q      <= '0;
			msg_q       <= '0;
		end else begin
			if (in.valid && in.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (load) begin
				phase_q  <= phase_d;
				v2_q     <= v2_d;
				hdr_q    <= hdr_d;
				fill_q   <= fill_d;
				plen_q   <= plen_d;
				signed_q <= signed_d;
				left_q   <= left_d;
				sys_q    <= sys_d;
				comp_q   <= comp_d;
				msg_q    <= msg_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			byte_s1 <= in.data_byte;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	`MFD_ASSERT_IMPL(a_done_xor_drop, clk, arst_n, out_valid_q, !(res_q.frame_done && res_q.overflow_drop))
	`MFD_ASSERT_IMPL(a_idle_pos_zero, clk, arst_n, out_valid_q && !res_q.in_frame, res_q.byte_pos == 9'd0)
	`MFD_ASSERT_NEXT(a_done_rehunt, clk, arst_n, load && (res_d.frame_done || res_d.overflow_drop), phase_q == mfd_pkg::PH_HUNT && fill_q == 9'd0)
	`MFD_ASSERT_IMPL(a_left_bound, clk, arst_n, phase_q == mfd_pkg::PH_REST, left_q <= mfd_pkg::MAX_REMAIN && left_q != 9'd0)

endmodule

### verif/mavlink_frame_deframer_test.sv
// Self-checking regression of the MAVLink frame deframer: directed and random byte streams.
`timescale 1ns / 100ps

module mavlink_frame_deframer_test;

	// Frame size limit of the block under test (its default).
	localparam int FRAME_LIMIT = 280;
	// Random stream length, counted in frame bytes (idle noise not counted).
	localparam int STREAM_BYTES = 1650;
	// Hard stop for a hung run; far above the slowest legal run.
	localparam int CYCLE_LIMIT = 500000;
	// Settle time after the last result: two register stages plus margin.
	localparam int DRAIN_CYCLES = 20;

	// One byte of stimulus. When fixed is set, want is the hand-typed result;
	// otherwise the result comes from the frame tracker below.
	typedef struct {
		logic [7:0]       data;
		bit               fixed;
		mfd_pkg::result_t want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mfd_in_if  byte_ch ();
	mfd_out_if res_ch ();

	mavlink_frame_deframer #(
		.MAX_FRAME(FRAME_LIMIT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (byte_ch),
		.out   (res_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Directed opening: idle bytes, a minimal v1 frame with an odd sequence
	// byte, then an unsigned v2 frame whose incompat byte and payload are
	// start bytes, then idle again.
	stim_t directed_rows [25] = '{
		'{8'h00, 1'b1, mfd_pkg::result_t'{echo_byte: 8'h00, default: '0}},
		'{8'hFF, 1'b1, mfd_pkg::result_t'{echo_byte: 8'hFF, default: '0}},
		'{8'h80, 1'b1, mfd_pkg::result_t'{echo_byte: 8'h80, default: '0}},
		'{mfd_pkg::STX_V1, 1'b1, mfd_pkg::result_t'{echo_byte: mfd_pkg::STX_V1,
			in_frame: 1'b1, default: '0}},
		'{8'h00, 1'b1, mfd_pkg::result_t'{echo_byte: 8'h00, in_frame: 1'b1,
			byte_pos: 9'd1, default: '0}},
		'{8'hA5, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'hC8, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h34, 1'b0, '0},
		'{8'h12, 1'b1, mfd_pkg::result_t'{echo_byte: 8'h12, in_frame: 1'b1,
			byte_pos: 9'd7, frame_done: 1'b1, frame_bytes: 9'd8, is_v2: 1'b0,
			payload_bytes: 8'd0, payload_start: mfd_pkg::HDR_V1, system_id: 8'h01,
			component_id: 8'hC8, message_id: 24'h0, overflow_drop: 1'b0}},
		'{mfd_pkg::STX_V2, 1'b1, mfd_pkg::result_t'{echo_byte: mfd_pkg::STX_V2,
			in_frame: 1'b1, default: '0}},
		'{8'h01, 1'b0, '0},
		'{mfd_pkg::STX_V1, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h07, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{mfd_pkg::STX_V2, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h80, 1'b1, mfd_pkg::result_t'{echo_byte: 8'h80, in_frame: 1'b1,
			byte_pos: 9'd12, frame_done: 1'b1, frame_bytes: 9'd13, is_v2: 1'b1,
			payload_bytes: 8'd1, payload_start: mfd_pkg::HDR_V2, system_id: 8'hFF,
			component_id: 8'h00, message_id: 24'hFFFFFF, overflow_drop: 1'b0}},
		'{8'h55, 1'b1, mfd_pkg::result_t'{echo_byte: 8'h55, default: '0}}
	};

	stim_t            tx_bytes [$];
	mfd_pkg::result_t expected_results [$];
	stim_t            inflight;
	mfd_pkg::result_t predicted;
	mfd_pkg::result_t oldest;
	int      gap_left = 0;
	int      hold_left = 0;
	int      transfers = 0;
	int      frame_octets = 0;
	int      fault_count = 0;
	int      cycle_count = 0;
	bit      calm = 1'b0;

	// Frame tracker state, mirrors what the block keeps between bytes.
	mfd_pkg::phase_t frame_phase = mfd_pkg::PH_HUNT;
	bit          frame_v2 = 1'b0;
	logic [3:0]  hdr_len = '0;
	logic [8:0]  fill_pos = '0;
	logic [7:0]  pay_len = '0;
	bit          sig_on = 1'b0;
	logic [8:0]  remain = '0;
	logic [7:0]  sys_id = '0;
	logic [7:0]  comp_id = '0;
	logic [23:0] msg_id = '0;

	// Advance the frame tracker by one byte and return the result it causes.
	task automatic deframe_byte(input logic [7:0] rx, output mfd_pkg::result_t r);
		logic [8:0] pos;
		bit         done;
		r = '0;
		done = 1'b0;
		r.echo_byte = rx;
		if (frame_phase == mfd_pkg::PH_HUNT) begin
			// Only a start byte opens a frame; anything else passes as idle.
			if (rx == mfd_pkg::STX_V1 || rx == mfd_pkg::STX_V2) begin
				frame_v2 = (rx == mfd_pkg::STX_V2);
				hdr_len = frame_v2 ? mfd_pkg::HDR_V2 : mfd_pkg::HDR_V1;
				sig_on = 1'b0;
				sys_id = '0;
				comp_id = '0;
				msg_id = '0;
				r.in_frame = 1'b1;
				fill_pos = 9'd1;
				frame_phase = mfd_pkg::PH_LEN;
			end
		end else begin
			r.in_frame = 1'b1;
			pos = fill_pos;
			r.byte_pos = pos;
			fill_pos = fill_pos + 9'd1;
			case (frame_phase)
				mfd_pkg::PH_LEN: begin
					pay_len = rx;
					frame_phase = mfd_pkg::PH_HEADER;
				end
				mfd_pkg::PH_HEADER: begin
					// Capture header fields; v1 has no incompat byte, so no signature.
					if (frame_v2) begin
						case (pos)
							9'd2: sig_on = rx[mfd_pkg::INCOMPAT_SIGNED_BIT];
							9'd5: sys_id = rx;
							9'd6: comp_id = rx;
							9'd7: msg_id[7:0] = rx;
							9'd8: msg_id[15:8] = rx;
							9'd9: msg_id[23:16] = rx;
							default: ;
						endcase
					end else begin
						case (pos)
							9'd3: sys_id = rx;
							9'd4: comp_id = rx;
							9'd5: msg_id = {16'h0, rx};
							default: ;
						endcase
					end
					if (fill_pos == {5'b0, hdr_len}) begin
						remain = {1'b0, pay_len} + mfd_pkg::CRC_BYTES +
							((frame_v2 && sig_on) ? mfd_pkg::SIG_BYTES : 9'd0);
						frame_phase = mfd_pkg::PH_REST;
					end
				end
				default: begin
					remain = remain - 9'd1;
					if (remain == 9'd0) begin
						done = 1'b1;
						r.frame_done = 1'b1;
						r.frame_bytes = fill_pos;
						r.is_v2 = frame_v2;
						r.payload_bytes = pay_len;
						r.payload_start = hdr_len;
						r.system_id = sys_id;
						r.component_id = comp_id;
						r.message_id = msg_id;
						frame_phase = mfd_pkg::PH_HUNT;
						fill_pos = '0;
					end
				end
			endcase
			// Size guard: only a byte that does not close the frame can trip it.
			if (!done && fill_pos >= FRAME_LIMIT) begin
				r.overflow_drop = 1'b1;
				frame_phase = mfd_pkg::PH_HUNT;
				fill_pos = '0;
			end
		end
	endtask

	// Gap length for either side: none in calm stretches, else mostly short.
	function automatic int draw_pause();
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Queue a well-formed frame with random header and body content.
	task automatic queue_frame(input bit v2, input bit signed_req, input logic [7:0] plen);
		int         hdr;
		int         body;
		logic [7:0] hb;
		hdr = v2 ? int'(mfd_pkg::HDR_V2) : int'(mfd_pkg::HDR_V1);
		body = int'(plen) + int'(mfd_pkg::CRC_BYTES)
			+ ((v2 && signed_req) ? int'(mfd_pkg::SIG_BYTES) : 0);
		tx_bytes.push_back('{v2 ? mfd_pkg::STX_V2 : mfd_pkg::STX_V1, 1'b0, '0});
		tx_bytes.push_back('{plen, 1'b0, '0});
		for (int i = 2; i < hdr; i++) begin
			hb = 8'($urandom_range(0, 255));
			if (v2 && i == 2)
				hb[mfd_pkg::INCOMPAT_SIGNED_BIT] = signed_req;
			tx_bytes.push_back('{hb, 1'b0, '0});
		end
		for (int i = 0; i < body; i++)
			tx_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0, '0});
		frame_octets += hdr + body;
	endtask

	task automatic compare_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fault_count++;
		end
	endtask

	// Byte sender: record each transfer in the tracker, then load the next
	// byte or idle. Valid gets one nonblocking update per edge at most.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				deframe_byte(byte_ch.data_byte, predicted);
				expected_results.push_back(inflight.fixed ? inflight.want : predicted);
				transfers++;
				// Switch between idling and back-to-back stretches now and then.
				if (transfers % 150 == 0)
					calm = ($urandom_range(0, 2) == 0);
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					byte_ch.valid <= 1'b0;
				end else if (tx_bytes.size() != 0) begin
					inflight = tx_bytes.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= inflight.data;
					gap_left = ($urandom_range(0, 2) == 0) ? draw_pause() : 0;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: check each transfer against the oldest expectation,
	// then hold ready low for a random stretch now and then.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h",
						$time, res_ch.res);
					fault_count++;
				end else begin
					oldest = expected_results.pop_front();
					compare_field("echo_byte", 24'(oldest.echo_byte),
						24'(res_ch.res.echo_byte));
					compare_field("in_frame", 24'(oldest.in_frame),
						24'(res_ch.res.in_frame));
					compare_field("byte_pos", 24'(oldest.byte_pos),
						24'(res_ch.res.byte_pos));
					compare_field("frame_done", 24'(oldest.frame_done),
						24'(res_ch.res.frame_done));
					compare_field("frame_bytes", 24'(oldest.frame_bytes),
						24'(res_ch.res.frame_bytes));
					compare_field("is_v2", 24'(oldest.is_v2), 24'(res_ch.res.is_v2));
					compare_field("payload_bytes", 24'(oldest.payload_bytes),
						24'(res_ch.res.payload_bytes));
					compare_field("payload_start", 24'(oldest.payload_start),
						24'(res_ch.res.payload_start));
					compare_field("system_id", 24'(oldest.system_id),
						24'(res_ch.res.system_id));
					compare_field("component_id", 24'(oldest.component_id),
						24'(res_ch.res.component_id));
					compare_field("message_id", oldest.message_id, res_ch.res.message_id);
					compare_field("overflow_drop", 24'(oldest.overflow_drop),
						24'(res_ch.res.overflow_drop));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold_left = draw_pause();
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("mavlink_frame_deframer regression: fail");
			$finish;
		end
	end

	initial begin : run_sequence
		int         frame_no;
		int         burst;
		bit         v2;
		bit         sg;
		bit         broken;
		logic [7:0] plen;
		logic [7:0] nb;

		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		res_ch.ready = 1'b0;

		foreach (directed_rows[i])
			tx_bytes.push_back(directed_rows[i]);

		// Random stream: mostly well-formed frames with small payloads, a few
		// full-size ones (a signed v2 frame of exactly the size limit among
		// them), and bursts of idle noise, some carrying stray start bytes.
		frame_no = 0;
		while (frame_octets < STREAM_BYTES) begin
			if ($urandom_range(0, 7) == 0) begin
				broken = ($urandom_range(0, 3) == 0);
				burst = $urandom_range(1, 6);
				for (int i = 0; i < burst; i++) begin
					nb = 8'($urandom_range(0, 255));
					// Keep a clean burst free of start bytes.
					while (!broken && (nb == mfd_pkg::STX_V1 || nb == mfd_pkg::STX_V2))
						nb = 8'($urandom_range(0, 255));
					tx_bytes.push_back('{nb, 1'b0, '0});
				end
			end
			v2 = 1'($urandom_range(0, 1));
			sg = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 19) == 0)
				plen = 8'($urandom_range(25, 254));
			else
				plen = 8'($urandom_range(0, 24));
			if (frame_no == 3) begin
				v2 = 1'b1;
				sg = 1'b1;
				plen = 8'd255;
			end else if (frame_no == 9) begin
				v2 = 1'b0;
				plen = 8'd255;
			end
			queue_frame(v2, sg, plen);
			frame_no++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every byte sent, every result in, then let the pipe settle.
		while (tx_bytes.size() != 0 || byte_ch.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0 && expected_results.size() == 0) begin
			$display("mavlink_frame_deframer regression: pass");
		end else begin
			$display("mavlink_frame_deframer regression: fail");
		end
		$finish;
	end

endmodule
